>>> rtl/sbce_pkg.sv
// shared constants and types of the stereo biquad cascade equalizer
package sbce_pkg;

    // default geometry and arithmetic widths
    localparam int NUM_BANDS_DEF    = 18;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 32;

    // fixed widths of the beat fields
    localparam int FIELD_SAMPLE_W = 24;
    localparam int FIELD_BAND_W   = 5;
    localparam int FIELD_SEL_W    = 3;
    localparam int FIELD_COEF_W   = 32;

    // integer bits above the fraction of a coefficient
    localparam int COEF_INT_BITS = 4;

    // item function codes
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // coefficient index within a band
    localparam int NUM_COEFS = 5;
    localparam logic [FIELD_SEL_W-1:0] COEF_B0 = 3'd0;
    localparam logic [FIELD_SEL_W-1:0] COEF_B1 = 3'd1;
    localparam logic [FIELD_SEL_W-1:0] COEF_B2 = 3'd2;
    localparam logic [FIELD_SEL_W-1:0] COEF_A1 = 3'd3;
    localparam logic [FIELD_SEL_W-1:0] COEF_A2 = 3'd4;

    // history row layout, one row per channel and band
    localparam int NUM_TAPS = 4;
    localparam int TAP_X1   = 0;
    localparam int TAP_X2   = 1;
    localparam int TAP_Y1   = 2;
    localparam int TAP_Y2   = 3;

    // steps of one section
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_HIST_RD   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_FIRST = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MUL_LAST  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ACC_FIRST = 3'd2;
    localparam logic [STEP_W-1:0] STEP_ACC_LAST  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_WB        = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } eq_state_t;

endpackage

>>> rtl/stereo_biquad_cascade_eq_core.sv
// stereo biquad cascade equalizer: sequencer, coefficient and history memories, shared mac
//
// Input channel (in_valid / in_stall): one beat is either a stereo frame (func = 0,
// left_in / right_in) or a single coefficient write (func = 1, band_select,
// coef_select, coef_value). A write gives no result and clears the history of
// that band in both channels; writes to a band or index out of range are
// dropped.
// Output channel (out_valid / out_stall): one beat of left_out / right_out per frame.
// A frame runs each channel through every band in turn on one shared multiplier:
// a section steps through five coefficient reads from the single coefficient
// memory port, multiply, accumulate, round, saturate and history write back, and
// after the last section the output register loads. in_stall stays high while
// the frame runs and until the output loads; the next frame or write is taken
// the cycle after the output loads.
// The output register holds a finished frame while out_stall is high; a following
// frame may still be taken and computed, and then waits until the register frees.
// Reset clears all coefficients and history to zero through per-entry valid bits,
// so the block is ready as soon as reset is released.
module stereo_biquad_cascade_eq_core #(
    parameter int NUM_BANDS    = sbce_pkg::NUM_BANDS_DEF,
    parameter int SAMPLE_WIDTH = sbce_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = sbce_pkg::COEF_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic                                      func,
    input  logic signed [sbce_pkg::FIELD_SAMPLE_W-1:0] left_in,
    input  logic signed [sbce_pkg::FIELD_SAMPLE_W-1:0] right_in,
    input  logic        [sbce_pkg::FIELD_BAND_W-1:0]   band_select,
    input  logic        [sbce_pkg::FIELD_SEL_W-1:0]    coef_select,
    input  logic signed [sbce_pkg::FIELD_COEF_W-1:0]   coef_value,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [sbce_pkg::FIELD_SAMPLE_W-1:0] left_out,
    output logic signed [sbce_pkg::FIELD_SAMPLE_W-1:0] right_out
);
    import sbce_pkg::*;

    localparam int COEF_FRAC  = COEF_WIDTH - COEF_INT_BITS;
    localparam int PROD_W     = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W      = PROD_W + 3;
    localparam int BAND_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int COEF_DEPTH = NUM_BANDS * NUM_COEFS;
    localparam int CADDR_W    = $clog2(COEF_DEPTH);
    localparam int HIST_DEPTH = 2 * NUM_BANDS;
    localparam int HADDR_W    = BAND_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_HALF =
        {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0] hist_row_t;

    // state and sequencer
    eq_state_t           state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [BAND_W-1:0]   band_reg;
    logic                chan_reg;
    logic                last_section;

    // strobes
    logic in_beat, frame_start, coef_we;
    logic coef_re, hist_re, hist_we, mul_en, acc_init, acc_en, out_load, out_free;

    // memories and their read data
    logic signed [COEF_WIDTH-1:0] coef_mem [COEF_DEPTH];
    logic signed [COEF_WIDTH-1:0] coef_q;
    logic [COEF_DEPTH-1:0]        coef_vld_reg;
    logic                         coef_rd_vld_reg;
    logic [CADDR_W-1:0]           coef_waddr, coef_raddr;
    logic [BAND_W-1:0]            wr_band;
    logic                         band_ok;

    hist_row_t                    hist_mem [HIST_DEPTH];
    hist_row_t                    hist_q, hist_row, hist_wdata;
    logic [HIST_DEPTH-1:0]        hist_vld_reg;
    logic                         hist_rd_vld_reg;
    logic [HADDR_W-1:0]           hist_addr;

    // datapath
    logic signed [SAMPLE_WIDTH-1:0] smp_reg [2];
    logic [STEP_W-1:0]              term;
    logic signed [SAMPLE_WIDTH-1:0] op_s;
    logic signed [COEF_WIDTH-1:0]   op_c;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           neg_reg;
    logic signed [ACC_W-1:0]        acc_reg, acc_shift;
    logic signed [SAMPLE_WIDTH-1:0] sec_y;

    logic                             out_valid_reg;
    logic [FIELD_SAMPLE_W-1:0]        left_out_reg, right_out_reg;

    // handshake decode
    assign in_beat     = in_valid && !in_stall;
    assign frame_start = in_beat && (func == FUNC_FRAME);
    assign band_ok     = {1'b0, band_select} < (FIELD_BAND_W+1)'(NUM_BANDS);
    assign coef_we     = in_beat && (func == FUNC_WRITE) && band_ok && (coef_select <= COEF_A2);
    assign wr_band     = band_select[BAND_W-1:0];
    assign out_free    = !out_valid_reg || !out_stall;

    assign coef_waddr = CADDR_W'(wr_band) * CADDR_W'(NUM_COEFS) + CADDR_W'(coef_select);
    assign coef_raddr = CADDR_W'(band_reg) * CADDR_W'(NUM_COEFS) + CADDR_W'(step_reg);
    assign hist_addr  = {band_reg, chan_reg};

    assign last_section = (band_reg == BAND_W'(NUM_BANDS - 1)) && chan_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if ((step_reg == STEP_WB) && last_section)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall = 1'b1;
        coef_re  = 1'b0;
        hist_re  = 1'b0;
        mul_en   = 1'b0;
        acc_init = 1'b0;
        acc_en   = 1'b0;
        hist_we  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_RUN:
            begin
                coef_re  = step_reg <= COEF_A2;
                hist_re  = step_reg == STEP_HIST_RD;
                acc_init = step_reg == STEP_HIST_RD;
                mul_en   = step_reg inside {[STEP_MUL_FIRST:STEP_MUL_LAST]};
                acc_en   = step_reg inside {[STEP_ACC_FIRST:STEP_ACC_LAST]};
                hist_we  = step_reg == STEP_WB;
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_HIST_RD;
            band_reg  <= '0;
            chan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (frame_start)
            begin
                step_reg <= STEP_HIST_RD;
                band_reg <= '0;
                chan_reg <= 1'b0;
            end
            else if (state_reg == ST_RUN)
            begin
                if (step_reg == STEP_WB)
                begin
                    step_reg <= STEP_HIST_RD;
                    chan_reg <= !chan_reg;
                    if (chan_reg)
                    begin
                        band_reg <= BAND_W'(band_reg + 1'b1);
                    end
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    // coefficient memory
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= COEF_WIDTH'(coef_value);
        end
        if (coef_re)
        begin
            coef_q <= coef_mem[coef_raddr];
        end
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_addr] <= hist_wdata;
        end
        if (hist_re)
        begin
            hist_q <= hist_mem[hist_addr];
        end
    end

    // entries never written since reset or since their band was reloaded read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg    <= '0;
            coef_rd_vld_reg <= 1'b0;
            hist_vld_reg    <= '0;
            hist_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (coef_we)
            begin
                coef_vld_reg[coef_waddr]      <= 1'b1;
                hist_vld_reg[{wr_band, 1'b0}] <= 1'b0;
                hist_vld_reg[{wr_band, 1'b1}] <= 1'b0;
            end
            if (hist_we)
            begin
                hist_vld_reg[hist_addr] <= 1'b1;
            end
            if (coef_re)
            begin
                coef_rd_vld_reg <= coef_vld_reg[coef_raddr];
            end
            if (hist_re)
            begin
                hist_rd_vld_reg <= hist_vld_reg[hist_addr];
            end
        end
    end

    assign hist_row = hist_rd_vld_reg ? hist_q : '0;

    // operand select, term index trails the registered coefficient read by one step
    assign term = step_reg - 1'b1;
    assign op_c = coef_rd_vld_reg ? coef_q : '0;

    always_comb
    begin
        case (term)
            COEF_B0: op_s = smp_reg[chan_reg];
            COEF_B1: op_s = hist_row[TAP_X1];
            COEF_B2: op_s = hist_row[TAP_X2];
            COEF_A1: op_s = hist_row[TAP_Y1];
            COEF_A2: op_s = hist_row[TAP_Y2];
            default: op_s = '0;
        endcase
    end

    // rounding constant preloads the accumulator
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= op_s * op_c;
            neg_reg  <= term >= COEF_A1;
        end
        if (acc_init)
        begin
            acc_reg <= ACC_HALF;
        end
        else if (acc_en)
        begin
            if (neg_reg)
            begin
                acc_reg <= acc_reg - ACC_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    assign acc_shift = acc_reg >>> COEF_FRAC;

    always_comb
    begin
        if (acc_shift > SAT_MAX)
        begin
            sec_y = SAT_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (acc_shift < SAT_MIN)
        begin
            sec_y = SAT_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            sec_y = acc_shift[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb
    begin
        hist_wdata         = hist_row;
        hist_wdata[TAP_X1] = smp_reg[chan_reg];
        hist_wdata[TAP_X2] = hist_row[TAP_X1];
        hist_wdata[TAP_Y1] = sec_y;
        hist_wdata[TAP_Y2] = hist_row[TAP_Y1];
    end

    // running sample of each channel, section output feeds the next band
    always_ff @(posedge clk)
    begin
        if (frame_start)
        begin
            smp_reg[0] <= SAMPLE_WIDTH'(left_in);
            smp_reg[1] <= SAMPLE_WIDTH'(right_in);
        end
        else if (hist_we)
        begin
            smp_reg[chan_reg] <= sec_y;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_out_reg  <= FIELD_SAMPLE_W'($unsigned(smp_reg[0]));
            right_out_reg <= FIELD_SAMPLE_W'($unsigned(smp_reg[1]));
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    // a new result shows up only from the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("out_valid rose outside the done state");

    // coefficient loads only happen between frames
    a_coef_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
        coef_we |-> (state_reg == ST_IDLE) && !hist_we && !coef_re)
        else $error("coefficient write during a frame");

    // a history row is never read and written back in the same cycle
    a_hist_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        hist_re |-> !hist_we)
        else $error("history read and write collide");

    // a taken beat with nothing new loaded empties the output register
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_load |=> !out_valid)
        else $error("output beat repeated");

    // the sequencer never walks past the last band while running
    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (band_reg <= BAND_W'(NUM_BANDS - 1)))
        else $error("band counter out of range");

endmodule

>>> test/tb_stereo_biquad_cascade_eq_core.sv
// testbench of the stereo biquad cascade equalizer: directed table, random phases, predictor
module tb_stereo_biquad_cascade_eq_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sbce_pkg::*;

    localparam int NB  = NUM_BANDS_DEF;
    localparam int SW  = SAMPLE_WIDTH_DEF;
    localparam int CW  = COEF_WIDTH_DEF;
    localparam int FRAC = CW - COEF_INT_BITS;
    localparam longint SAT_MAX = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint SAT_MIN = -(64'sd1 <<< (SW - 1));
    localparam int RANDOM_BEATS = 600;

    typedef struct {
        logic                      func;
        logic [FIELD_SAMPLE_W-1:0] left;
        logic [FIELD_SAMPLE_W-1:0] right;
        logic [FIELD_BAND_W-1:0]   band;
        logic [FIELD_SEL_W-1:0]    sel;
        logic [FIELD_COEF_W-1:0]   coef;
        bit                        known;
        logic [FIELD_SAMPLE_W-1:0] known_l;
        logic [FIELD_SAMPLE_W-1:0] known_r;
    } eq_beat_t;

    typedef struct packed {
        logic [FIELD_SAMPLE_W-1:0] l;
        logic [FIELD_SAMPLE_W-1:0] r;
    } stereo_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = FUNC_FRAME;
    logic signed [FIELD_SAMPLE_W-1:0] left_in = '0;
    logic signed [FIELD_SAMPLE_W-1:0] right_in = '0;
    logic [FIELD_BAND_W-1:0] band_select = '0;
    logic [FIELD_SEL_W-1:0] coef_select = '0;
    logic signed [FIELD_COEF_W-1:0] coef_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [FIELD_SAMPLE_W-1:0] left_out;
    logic signed [FIELD_SAMPLE_W-1:0] right_out;

    // predictor state
    logic signed [CW-1:0] band_coef [NB][NUM_COEFS];
    logic signed [SW-1:0] band_hist [2][NB][NUM_TAPS];

    stereo_t expected_frames [$];
    eq_beat_t directed_beats [$];
    int mismatches = 0;
    int frames_checked = 0;
    int writes_taken = 0;
    int writes_dropped = 0;
    int beats_counted = 0;
    bit steady = 1'b0;

    stereo_biquad_cascade_eq_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .left_in     (left_in),
        .right_in    (right_in),
        .band_select (band_select),
        .coef_select (coef_select),
        .coef_value  (coef_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_out    (left_out),
        .right_out   (right_out)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d frames outstanding", expected_frames.size());
        $display("FAIL");
        $finish;
    end

    function automatic logic signed [SW-1:0] run_band(int ch, int band,
                                                       logic signed [SW-1:0] x);
        longint acc;
        longint q;
        logic signed [SW-1:0] y;
        acc = longint'(x) * longint'(band_coef[band][COEF_B0])
            + longint'(band_hist[ch][band][TAP_X1]) * longint'(band_coef[band][COEF_B1])
            + longint'(band_hist[ch][band][TAP_X2]) * longint'(band_coef[band][COEF_B2])
            - longint'(band_hist[ch][band][TAP_Y1]) * longint'(band_coef[band][COEF_A1])
            - longint'(band_hist[ch][band][TAP_Y2]) * longint'(band_coef[band][COEF_A2]);
        // round half up, then saturate to the sample width
        q = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (q > SAT_MAX)
            y = SAT_MAX[SW-1:0];
        else if (q < SAT_MIN)
            y = SAT_MIN[SW-1:0];
        else
            y = q[SW-1:0];
        band_hist[ch][band][TAP_X2] = band_hist[ch][band][TAP_X1];
        band_hist[ch][band][TAP_X1] = x;
        band_hist[ch][band][TAP_Y2] = band_hist[ch][band][TAP_Y1];
        band_hist[ch][band][TAP_Y1] = y;
        return y;
    endfunction

    // update the predictor with an accepted beat and queue the frame it yields
    function automatic void apply_beat(eq_beat_t b);
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
        stereo_t res;
        if (b.func == FUNC_WRITE)
        begin
            if (b.band < NB && b.sel <= COEF_A2)
            begin
                band_coef[b.band][b.sel] = b.coef;
                for (int c = 0; c < 2; c++)
                    for (int t = 0; t < NUM_TAPS; t++)
                        band_hist[c][b.band][t] = '0;
                writes_taken++;
                beats_counted++;
            end
            else
            begin
                writes_dropped++;
            end
        end
        else
        begin
            l = b.left;
            r = b.right;
            for (int k = 0; k < NB; k++)
            begin
                l = run_band(0, k, l);
                r = run_band(1, k, r);
            end
            res.l = b.known ? b.known_l : l;
            res.r = b.known ? b.known_r : r;
            expected_frames.push_back(res);
            beats_counted++;
        end
    endfunction

    function automatic eq_beat_t make_beat(logic f, logic [23:0] l, logic [23:0] r,
                                           logic [4:0] band, logic [2:0] sel,
                                           logic [31:0] coef, bit known);
        eq_beat_t b;
        b.func = f;
        b.left = l;
        b.right = r;
        b.band = band;
        b.sel = sel;
        b.coef = coef;
        b.known = known;
        b.known_l = '0;
        b.known_r = '0;
        return b;
    endfunction

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2, 3: return 24'(int'($urandom_range(0, 8192)) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    // unused write fields carry random content on a frame beat
    function automatic eq_beat_t frame_beat();
        return make_beat(FUNC_FRAME, pick_sample(), pick_sample(), 5'($urandom),
                         3'($urandom), $urandom, 1'b0);
    endfunction

    function automatic eq_beat_t coef_beat(int band, int sel, logic [31:0] coef);
        return make_beat(FUNC_WRITE, 24'($urandom), 24'($urandom), 5'(band), 3'(sel),
                         coef, 1'b0);
    endfunction

    // a coefficient of a tame section: gain near one or two, small feedback
    function automatic logic [31:0] tame_coef(int sel);
        int v;
        v = int'($urandom_range(0, 1 << 26)) - (1 << 25);
        if (sel == COEF_B0)
            v = v + (($urandom_range(0, 7) == 0) ? (1 << (FRAC + 1)) : (1 << FRAC));
        return v;
    endfunction

    task automatic send_beat(eq_beat_t b);
        steady <= (beats_counted >= 250 && beats_counted < 400);
        while (!steady && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= b.func;
        left_in <= b.left;
        right_in <= b.right;
        band_select <= b.band;
        coef_select <= b.sel;
        coef_value <= b.coef;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_beat(b);
    endtask

    // output side: random stall, compare each beat with the oldest expected frame
    always @(posedge clk or negedge rst_n)
    begin
        stereo_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected frame l=%h r=%h", left_out, right_out);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    frames_checked++;
                    if (left_out !== want.l || right_out !== want.r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("frame %0d: expected l=%h r=%h, got l=%h r=%h",
                                     frames_checked, want.l, want.r, left_out, right_out);
                    end
                end
            end
            out_stall <= !steady && ($urandom_range(0, 99) < 29);
        end
    end

    initial
    begin
        int mode;
        int n;
        for (int k = 0; k < NB; k++)
        begin
            for (int s = 0; s < NUM_COEFS; s++)
                band_coef[k][s] = '0;
            for (int c = 0; c < 2; c++)
                for (int t = 0; t < NUM_TAPS; t++)
                    band_hist[c][k][t] = '0;
        end

        // extremes, ignored writes and unused fields; zero where the cascade is still empty
        directed_beats.push_back(make_beat(FUNC_FRAME, 24'h7FFFFF, 24'h800000, 5'd31,
                                           COEF_A2 + 3'd3, 32'hFFFFFFFF, 1'b1));
        directed_beats.push_back(make_beat(FUNC_FRAME, 24'h800000, 24'h7FFFFF, 5'd0,
                                           COEF_B0, 32'h0, 1'b1));
        directed_beats.push_back(make_beat(FUNC_WRITE, 24'h7FFFFF, 24'h800000, 5'd18,
                                           COEF_B0, 32'h10000000, 1'b0));
        directed_beats.push_back(make_beat(FUNC_WRITE, 24'h0, 24'h0, 5'd31, COEF_A2,
                                           32'h10000000, 1'b0));
        directed_beats.push_back(make_beat(FUNC_WRITE, 24'h0, 24'h0, 5'd0, COEF_A2 + 3'd1,
                                           32'h10000000, 1'b0));
        directed_beats.push_back(make_beat(FUNC_WRITE, 24'h0, 24'h0, 5'd3, COEF_A2 + 3'd3,
                                           32'h7FFFFFFF, 1'b0));
        directed_beats.push_back(make_beat(FUNC_FRAME, 24'h7FFFFF, 24'h7FFFFF, 5'd0,
                                           COEF_B0, 32'h0, 1'b1));
        directed_beats.push_back(make_beat(FUNC_WRITE, 24'h0, 24'h0, 5'd0, COEF_B0,
                                           32'h7FFFFFFF, 1'b0));
        directed_beats.push_back(make_beat(FUNC_WRITE, 24'h0, 24'h0, 5'd0, COEF_B1,
                                           32'h80000000, 1'b0));
        directed_beats.push_back(make_beat(FUNC_WRITE, 24'h0, 24'h0, 5'd0, COEF_B2,
                                           32'h10000000, 1'b0));
        directed_beats.push_back(make_beat(FUNC_WRITE, 24'h0, 24'h0, 5'd0, COEF_A1,
                                           32'h80000000, 1'b0));
        directed_beats.push_back(make_beat(FUNC_WRITE, 24'h0, 24'h0, 5'd0, COEF_A2,
                                           32'h7FFFFFFF, 1'b0));
        // band 1 still zero, so the cascade output stays zero
        directed_beats.push_back(make_beat(FUNC_FRAME, 24'h7FFFFF, 24'h800000, 5'd17,
                                           COEF_A1, 32'h12345678, 1'b1));
        directed_beats.push_back(make_beat(FUNC_FRAME, 24'h000001, 24'hFFFFFF, 5'd0,
                                           COEF_B0, 32'h0, 1'b1));
        directed_beats.push_back(make_beat(FUNC_WRITE, 24'h0, 24'h0, 5'd17, COEF_B0,
                                           32'h80000000, 1'b0));
        directed_beats.push_back(make_beat(FUNC_WRITE, 24'h0, 24'h0, 5'd17, COEF_A2,
                                           32'h7FFFFFFF, 1'b0));
        directed_beats.push_back(make_beat(FUNC_FRAME, 24'h123456, 24'hABCDEF, 5'd0,
                                           COEF_B0, 32'h0, 1'b1));
        directed_beats.push_back(make_beat(FUNC_WRITE, 24'h0, 24'h0, 5'd0, COEF_B0,
                                           32'h0, 1'b0));
        directed_beats.push_back(make_beat(FUNC_FRAME, 24'h0, 24'h0, 5'd0, COEF_B0,
                                           32'h0, 1'b1));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_beats[i])
            send_beat(directed_beats[i]);

        beats_counted = 0;
        while (beats_counted < RANDOM_BEATS)
        begin
            mode = $urandom_range(0, 9);
            if (mode <= 5)
            begin
                // well-formed reload of the whole cascade
                for (int k = 0; k < NB; k++)
                    for (int s = 0; s < NUM_COEFS; s++)
                        send_beat(coef_beat(k, s, tame_coef(s)));
            end
            else if (mode <= 7)
            begin
                // a few scattered writes, some out of range
                n = $urandom_range(1, 8);
                repeat (n)
                    send_beat(coef_beat($urandom_range(0, 31), $urandom_range(0, 7),
                                        $urandom));
            end
            else
            begin
                // full-range coefficients drive the sections into saturation
                for (int k = 0; k < NB; k++)
                    for (int s = 0; s < NUM_COEFS; s++)
                        send_beat(coef_beat(k, s, (mode == 8) ? $urandom :
                                            ((s == COEF_B0) ? 32'h7FFFFFFF : 32'h0)));
            end
            n = $urandom_range(20, 60);
            repeat (n)
                send_beat(frame_beat());
        end
        in_valid <= 1'b0;

        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (320) @(posedge clk);

        $display("checked %0d frames; %0d coefficient writes taken, %0d dropped",
                 frames_checked, writes_taken, writes_dropped);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
